FILE: rtl/kstar_count_bounds_top_assert.svh
// Assertion macros shared by the k-star bound counter RTL.
// Used by kstar_count_bounds_top; relies on clk and rst_n in the including scope.
`ifndef KSTAR_COUNT_BOUNDS_TOP_ASSERT_SVH
`define KSTAR_COUNT_BOUNDS_TOP_ASSERT_SVH

`define KCB_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("kcb assertion failed");

`define KCB_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kcb assertion failed");

`endif

FILE: rtl/kcb_pkg.sv
// Package for the k-star bound counter: constants, state types, status struct.
// No dependencies; used by kcb_binom and kstar_count_bounds_top.
`default_nettype none

package kcb_pkg;

    localparam int MAX_STAR_DEF = 32;
    localparam logic [5:0] STAR_RESET = 6'd3;
    localparam logic REG_STAR = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_START,
        ST_UP_WAIT,
        ST_LO_START,
        ST_LO_WAIT,
        ST_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_MUL_LO,
        B_MUL_HI,
        B_DIV
    } bin_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bin_stat_t;

endpackage

`default_nettype wire

FILE: rtl/kcb_binom.sv
// Iterative binomial unit: one 32x32 multiplier and a bit-serial divider.
// Depends on kcb_pkg.
`default_nettype none

module kcb_binom #(
    parameter int MaxStar = kcb_pkg::MAX_STAR_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [31:0]                        n,
    input  wire logic [$clog2(MaxStar + 1) - 1:0]   m,
    output kcb_pkg::bin_stat_t                      stat,
    output logic [63:0]                             result
);

    localparam int JW = $clog2(MaxStar + 1);

    kcb_pkg::bin_state_t state_reg, state_next;
    logic [63:0]   c_reg, c_next;
    logic [63:0]   q_reg, q_next;
    logic [JW-1:0] j_reg, j_next;
    logic [JW-1:0] m_reg, m_next;
    logic [31:0]   n_reg, n_next;
    logic [JW-1:0] rem_reg, rem_next;
    logic [5:0]    bit_reg, bit_next;
    logic          done_reg, done_next;

    logic [31:0] f;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [JW:0] rem_sh;

    assign f      = n_reg - 32'(m_reg) + 32'(j_reg);
    assign mul_b  = (state_reg == kcb_pkg::B_MUL_HI) ? c_reg[63:32] : c_reg[31:0];
    assign mul_p  = 64'(f) * 64'(mul_b);
    assign rem_sh = {rem_reg, q_reg[63]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kcb_pkg::B_IDLE:   if (start) state_next = kcb_pkg::B_CHECK;
            kcb_pkg::B_CHECK:  state_next = (j_reg > m_reg) ? kcb_pkg::B_IDLE
                                                            : kcb_pkg::B_MUL_LO;
            kcb_pkg::B_MUL_LO: state_next = kcb_pkg::B_MUL_HI;
            kcb_pkg::B_MUL_HI: state_next = kcb_pkg::B_DIV;
            kcb_pkg::B_DIV:    if (bit_reg == 6'd63) state_next = kcb_pkg::B_CHECK;
            default:           state_next = kcb_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        c_next    = c_reg;
        q_next    = q_reg;
        j_next    = j_reg;
        m_next    = m_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        unique case (state_reg)
            kcb_pkg::B_IDLE:
            begin
                if (start)
                begin
                    c_next = 64'd1;
                    j_next = JW'(1);
                    m_next = m;
                    n_next = n;
                end
            end
            kcb_pkg::B_CHECK:
            begin
                if (j_reg > m_reg) done_next = 1'b1;
            end
            kcb_pkg::B_MUL_LO:
            begin
                q_next = mul_p;
            end
            kcb_pkg::B_MUL_HI:
            begin
                q_next   = {q_reg[63:32] + mul_p[31:0], q_reg[31:0]};
                rem_next = '0;
                bit_next = '0;
            end
            kcb_pkg::B_DIV:
            begin
                if (rem_sh >= {1'b0, j_reg})
                begin
                    rem_next = JW'(rem_sh - {1'b0, j_reg});
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[JW-1:0];
                    q_next   = {q_reg[62:0], 1'b0};
                end
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd63)
                begin
                    c_next = {q_reg[62:0], (rem_sh >= {1'b0, j_reg})};
                    j_next = j_reg + JW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kcb_pkg::B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        q_reg   <= q_next;
        j_reg   <= j_next;
        m_reg   <= m_next;
        n_reg   <= n_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
    end

    assign stat.busy = (state_reg != kcb_pkg::B_IDLE);
    assign stat.done = done_reg;
    assign result    = c_reg;

endmodule

`default_nettype wire

FILE: rtl/kstar_count_bounds_top.sv
// K-star bound counter: a neighbor entry that does not close its node is taken without
// leaving the idle state. A node close runs up to two binomials on one shared unit. Each
// binomial runs, per factor, a check, a low and a high multiply step and a bit-serial
// divide over 64 quotient bits, followed by a final check. The top launches each binomial
// from a start state and waits for it in a wait state. A close therefore holds in_ready
// low until both binomials are done or skipped. At graph end an emit state hands over the
// result, and it waits while an earlier result has not yet been taken. The output
// register lets a new request enter while the last result waits.
// Depends on kcb_pkg, kcb_binom and kstar_count_bounds_top_assert.svh.
`default_nettype none

module kstar_count_bounds_top #(
    parameter int MaxStar = kcb_pkg::MAX_STAR_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] node_id,
    input  wire logic [31:0] neighbor_id,
    input  wire logic        has_neighbor,
    input  wire logic        end_of_node,
    input  wire logic        end_of_graph,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      upper_bound,
    output logic [63:0]      lower_bound
);

    localparam int JW = $clog2(MaxStar + 1);

    kcb_pkg::top_state_t state_reg, state_next;
    logic [5:0]  star_reg;
    logic [31:0] degree_reg, degree_next;
    logic [31:0] higher_reg, higher_next;
    logic [63:0] upper_reg, upper_next;
    logic [63:0] lower_reg, lower_next;
    logic        eog_reg, eog_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_up_reg, out_up_next;
    logic [63:0] out_lo_reg, out_lo_next;

    logic               accept;
    logic [JW-1:0]      k_eff;
    logic [JW-1:0]      m_val;
    logic               k_zero;
    logic               bin_start;
    logic [31:0]        bin_n;
    kcb_pkg::bin_stat_t bin_stat;
    logic [63:0]        bin_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == kcb_pkg::REG_STAR) ? {26'd0, star_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            star_reg <= kcb_pkg::STAR_RESET;
        else if (psel && penable && pwrite && paddr[2] == kcb_pkg::REG_STAR)
            star_reg <= pwdata[5:0];
    end

    assign k_eff  = ({1'b0, star_reg} > 7'(MaxStar)) ? JW'(MaxStar) : JW'(star_reg);
    assign k_zero = (k_eff == '0);
    assign m_val  = k_eff - JW'(1);

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == kcb_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kcb_pkg::ST_IDLE:
                if (accept && (end_of_node || end_of_graph))
                    state_next = kcb_pkg::ST_UP_START;
            kcb_pkg::ST_UP_START:
                state_next = (!k_zero && degree_reg >= 32'(m_val)) ? kcb_pkg::ST_UP_WAIT
                                                                    : kcb_pkg::ST_LO_START;
            kcb_pkg::ST_UP_WAIT:
                if (bin_stat.done) state_next = kcb_pkg::ST_LO_START;
            kcb_pkg::ST_LO_START:
                if (!k_zero && higher_reg >= 32'(m_val))
                    state_next = kcb_pkg::ST_LO_WAIT;
                else
                    state_next = eog_reg ? kcb_pkg::ST_EMIT : kcb_pkg::ST_IDLE;
            kcb_pkg::ST_LO_WAIT:
                if (bin_stat.done)
                    state_next = eog_reg ? kcb_pkg::ST_EMIT : kcb_pkg::ST_IDLE;
            kcb_pkg::ST_EMIT:
                if (!out_valid_reg || out_ready) state_next = kcb_pkg::ST_IDLE;
            default:
                state_next = kcb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        degree_next    = degree_reg;
        higher_next    = higher_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        eog_next       = eog_reg;
        out_up_next    = out_up_reg;
        out_lo_next    = out_lo_reg;
        out_valid_next = out_valid_reg && !out_ready;
        bin_start      = 1'b0;
        bin_n          = degree_reg;
        unique case (state_reg)
            kcb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    eog_next = end_of_graph;
                    if (has_neighbor)
                    begin
                        degree_next = degree_reg + 32'd1;
                        if (neighbor_id > node_id) higher_next = higher_reg + 32'd1;
                    end
                end
            end
            kcb_pkg::ST_UP_START:
            begin
                bin_start = !k_zero && degree_reg >= 32'(m_val);
            end
            kcb_pkg::ST_UP_WAIT:
            begin
                if (bin_stat.done) upper_next = upper_reg + bin_res;
            end
            kcb_pkg::ST_LO_START:
            begin
                bin_n     = higher_reg;
                bin_start = !k_zero && higher_reg >= 32'(m_val);
                if (!bin_start)
                begin
                    degree_next = '0;
                    higher_next = '0;
                end
            end
            kcb_pkg::ST_LO_WAIT:
            begin
                bin_n = higher_reg;
                if (bin_stat.done)
                begin
                    lower_next  = lower_reg + bin_res;
                    degree_next = '0;
                    higher_next = '0;
                end
            end
            kcb_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_up_next    = upper_reg;
                    out_lo_next    = lower_reg;
                    out_valid_next = 1'b1;
                    upper_next     = '0;
                    lower_next     = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kcb_pkg::ST_IDLE;
            degree_reg    <= '0;
            higher_reg    <= '0;
            upper_reg     <= '0;
            lower_reg     <= '0;
            eog_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            degree_reg    <= degree_next;
            higher_reg    <= higher_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            eog_reg       <= eog_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_up_reg <= out_up_next;
        out_lo_reg <= out_lo_next;
    end

    kcb_binom #(
        .MaxStar (MaxStar)
    ) u_binom (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bin_start),
        .n      (bin_n),
        .m      (m_val),
        .stat   (bin_stat),
        .result (bin_res)
    );

    assign out_valid   = out_valid_reg;
    assign upper_bound = out_up_reg;
    assign lower_bound = out_lo_reg;

`include "kstar_count_bounds_top_assert.svh"

    `KCB_ASSERT_SAME(a_start_free, bin_start, !bin_stat.busy)
    `KCB_ASSERT_SAME(a_ready_unit_idle, in_ready, !bin_stat.busy)
    `KCB_ASSERT_NEXT(a_done_pulse, bin_stat.done, !bin_stat.done)

endmodule

`default_nettype wire

FILE: test/kcb_checker.sv
`timescale 1ns / 100ps
// Checker for the k-star bound counter: follows the star_size register writes,
// predicts the bound sums of each graph from the accepted requests and compares each result.
// Depends on kcb_pkg for the register index.
module kcb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] node_id,
    input  logic [31:0] neighbor_id,
    input  logic        has_neighbor,
    input  logic        end_of_node,
    input  logic        end_of_graph,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] upper_bound,
    input  logic [63:0] lower_bound,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
    } bounds_t;

    logic [5:0]  k_reg;
    logic [31:0] deg_cnt;
    logic [31:0] hi_cnt;
    logic [63:0] up_acc;
    logic [63:0] lo_acc;
    bounds_t     bounds_q[$];

    function automatic logic [63:0] choose(input logic [31:0] n, input int m);
        logic [63:0] c;
        logic [63:0] f;
        c = 64'd1;
        for (int j = 1; j <= m; j++)
        begin
            f = 64'(n) - 64'(m) + 64'(j);
            c = (f * c) / 64'(j);
        end
        return c;
    endfunction

    assign pending = bounds_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        bounds_t     got;
        bounds_t     exp_b;
        logic [31:0] d;
        logic [31:0] h;
        int          k;
        if (!rst_n)
        begin
            k_reg      <= kcb_pkg::STAR_RESET;
            deg_cnt    <= '0;
            hi_cnt     <= '0;
            up_acc     <= '0;
            lo_acc     <= '0;
            fail_count <= 0;
            bounds_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == {kcb_pkg::REG_STAR, 2'b00})
                k_reg <= pwdata[5:0];
            if (out_valid && out_ready)
            begin
                got.upper = upper_bound;
                got.lower = lower_bound;
                if (bounds_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: upper %h lower %h", got.upper,
                                 got.lower);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_b = bounds_q.pop_front();
                    if (exp_b != got)
                    begin
                        if (fail_count < 10)
                            $display("result mismatch: expected upper %h lower %h, got %h %h",
                                     exp_b.upper, exp_b.lower, got.upper, got.lower);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                d = deg_cnt;
                h = hi_cnt;
                exp_b.upper = up_acc;
                exp_b.lower = lo_acc;
                if (has_neighbor)
                begin
                    d = d + 1;
                    if (neighbor_id > node_id)
                        h = h + 1;
                end
                if (end_of_node || end_of_graph)
                begin
                    k = (int'(k_reg) > kcb_pkg::MAX_STAR_DEF) ? kcb_pkg::MAX_STAR_DEF
                                                               : int'(k_reg);
                    if (k != 0)
                    begin
                        if (d >= 32'(k - 1))
                            exp_b.upper = exp_b.upper + choose(d, k - 1);
                        if (h >= 32'(k - 1))
                            exp_b.lower = exp_b.lower + choose(h, k - 1);
                    end
                    d = '0;
                    h = '0;
                end
                if (end_of_graph)
                begin
                    bounds_q.push_back(exp_b);
                    exp_b.upper = '0;
                    exp_b.lower = '0;
                end
                deg_cnt <= d;
                hi_cnt  <= h;
                up_acc  <= exp_b.upper;
                lo_acc  <= exp_b.lower;
            end
        end
    end
endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench top for kstar_count_bounds_top: streams directed and random graphs
// under several star sizes and gives the verdict. Depends on kcb_pkg and kcb_checker.
module tb;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] node_id;
    logic [31:0] neighbor_id;
    logic        has_neighbor;
    logic        end_of_node;
    logic        end_of_graph;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] upper_bound;
    logic [63:0] lower_bound;
    int          fail_count;
    int          pending;
    int          sent;
    bit          no_gaps;

    kstar_count_bounds_top dut (.*);

    kcb_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = (gap_len() == 0);
        end
    end

    task automatic write_star(input logic [5:0] k);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {kcb_pkg::REG_STAR, 2'b00};
        pwdata  = {$urandom_range(0, 3) == 0 ? 26'($urandom) : 26'd0, k};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send(input logic [31:0] node, input logic [31:0] nbr, input logic has,
                        input logic eon, input logic eog);
        int g;
        g = gap_len();
        repeat (g) @(negedge clk);
        in_valid     = 1'b1;
        node_id      = node;
        neighbor_id  = nbr;
        has_neighbor = has;
        end_of_node  = eon;
        end_of_graph = eog;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid     = 1'b0;
        node_id      = $urandom;
        neighbor_id  = $urandom;
        has_neighbor = 1'($urandom);
        end_of_node  = 1'($urandom);
        end_of_graph = 1'($urandom);
        sent++;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_label();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'hFFFF_FFFF;
        if (r == 1)
            return 32'd0;
        if (r < 4)
            return $urandom;
        return $urandom_range(0, 15);
    endfunction

    task automatic random_graph(input int nodes, input int max_deg);
        int          deg;
        logic [31:0] node;
        logic [31:0] nbr;
        bit          last;
        for (int n = 0; n < nodes; n++)
        begin
            last = (n == nodes - 1);
            node = pick_label();
            deg  = $urandom_range(0, max_deg);
            if (deg == 0)
                send(node, $urandom, 1'b0, ~last | 1'($urandom), last);
            for (int e = 0; e < deg; e++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send(node, $urandom, 1'b0, 1'b0, 1'b0);
                nbr = ($urandom_range(0, 7) == 0) ? node : pick_label();
                if (e == deg - 1)
                    send(node, nbr, 1'b1, ~last | 1'($urandom), last);
                else
                    send(node, nbr, 1'b1, 1'b0, 1'b0);
            end
        end
    endtask

    initial
    begin
        logic [5:0] k;
        int         ph;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        node_id      = '0;
        neighbor_id  = '0;
        has_neighbor = 1'b0;
        end_of_node  = 1'b0;
        end_of_graph = 1'b0;
        sent         = 0;
        no_gaps      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        send(32'd5, 32'd9, 1'b1, 1'b0, 1'b0);
        send(32'd5, 32'd5, 1'b1, 1'b0, 1'b0);
        send(32'd5, 32'd1, 1'b1, 1'b0, 1'b0);
        send(32'd5, 32'd0, 1'b0, 1'b0, 1'b0);
        send(32'd5, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        send(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, 1'b0);
        send(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        send(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        send(32'd0, 32'd7, 1'b1, 1'b0, 1'b0);
        send(32'd0, 32'd8, 1'b1, 1'b0, 1'b1);
        send(32'd3, 32'd4, 1'b0, 1'b0, 1'b1);
        send(32'd3, 32'd4, 1'b1, 1'b1, 1'b1);
        wait_drained();
        write_star(6'd1);
        send(32'd2, 32'd1, 1'b1, 1'b1, 1'b0);
        send(32'd2, 32'd1, 1'b0, 1'b1, 1'b1);
        wait_drained();
        write_star(6'd0);
        send(32'd2, 32'd3, 1'b1, 1'b1, 1'b1);
        wait_drained();
        write_star(6'd63);
        random_graph(2, 40);
        wait_drained();

        ph = 0;
        while (sent < 850)
        begin
            case (ph % 8)
                0: k = 6'd2;
                1: k = 6'd32;
                2: k = 6'd0;
                3: k = 6'd1;
                4: k = 6'd33;
                default: k = 6'($urandom_range(2, 7));
            endcase
            write_star(k);
            for (int g = 0; g < 6; g++)
            begin
                no_gaps = ($urandom_range(0, 3) == 0);
                if (k >= 8)
                    random_graph($urandom_range(1, 3), (g == 0) ? 40 : 6);
                else
                    random_graph($urandom_range(1, 6), 6);
                if (g == 2 && ph == 1)
                    wait_drained();
            end
            wait_drained();
            ph++;
        end
        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("kstar_count_bounds_top: match");
        else
            $display("kstar_count_bounds_top: mismatch");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("kstar_count_bounds_top: mismatch");
        $finish;
    end
endmodule
